[src/psfr_pkg.sv]
`default_nettype none
package psfr_pkg;

  localparam int MAC_W  = 33;   // shared multiplier operand width
  localparam int ACC_W  = 68;   // accumulator width
  localparam int CW     = 36;   // cordic datapath width
  localparam int ITER_W = 6;    // cordic step counter width

  // configuration register indexes
  localparam logic [2:0] CFG_SMALL_ID      = 3'd0;
  localparam logic [2:0] CFG_ALPHA_SMALL   = 3'd1;
  localparam logic [2:0] CFG_ALPHA_DEFAULT = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT       = 3'd3;
  localparam logic [2:0] CFG_FLIP_COS      = 3'd4;

  // pose status codes
  localparam logic [1:0] POSE_BLENDED = 2'd0;
  localparam logic [1:0] POSE_SNAPPED = 2'd1;
  localparam logic [1:0] POSE_HELD    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_MAC, ST_MWAIT, ST_FLIP, ST_SQRT, ST_ATAN,
    ST_SIN_TH, ST_WEIGHT, ST_SIN0, ST_DIV0, ST_SIN1, ST_DIV1, ST_WRITE
  } state_t;

  // multiply-accumulate groups, in sequence order
  typedef enum logic [3:0] {
    G_DOT, G_TX, G_TY, G_TZ, G_PSQ, G_T0, G_T1, G_QX, G_QY, G_QZ, G_QW
  } group_t;

  typedef struct packed {
    logic start;
    logic vec;     // 1: vectoring (atan2), 0: rotation (sine)
  } cordic_cmd_t;

  typedef struct packed {
    logic [47:0]        seen;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [3:0][15:0]   quat;
  } pose_rec_t;

  // atan(2^-i) in Q30 radians
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021688;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388438;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097150;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/psfr_mac.sv]
`default_nettype none
module psfr_mac (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              issue,
  input  wire logic                              fresh,
  input  wire logic signed [psfr_pkg::MAC_W-1:0] op_a,
  input  wire logic signed [psfr_pkg::MAC_W-1:0] op_b,
  output logic signed [psfr_pkg::ACC_W-1:0]      acc
);
  import psfr_pkg::*;

  logic signed [2*MAC_W-1:0] prod;
  logic                      prod_v;
  logic                      prod_fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= issue;
    end
    prod       <= op_a * op_b;
    prod_fresh <= fresh;
    if (prod_v) begin
      acc <= prod_fresh ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

endmodule
`default_nettype wire

[src/psfr_cordic.sv]
`default_nettype none
module psfr_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psfr_pkg::cordic_cmd_t          cmd,
  input  wire logic signed [psfr_pkg::CW-1:0] x_in,
  input  wire logic signed [psfr_pkg::CW-1:0] y_in,
  input  wire logic signed [psfr_pkg::CW-1:0] z_in,
  output logic                                done,
  output logic signed [psfr_pkg::CW-1:0]      y_out,
  output logic signed [psfr_pkg::CW-1:0]      z_out
);
  import psfr_pkg::*;

  logic signed [CW-1:0] x, y, z;
  logic [ITER_W-1:0]    i;
  logic                 busy;
  logic                 vec;
  logic signed [CW-1:0] dx, dy, at;
  logic                 up;

  assign dx = y >>> i[4:0];
  assign dy = x >>> i[4:0];
  assign at = CW'(atan_q30(i[4:0]));
  // vectoring drives y to zero, rotation drives z to zero
  assign up = vec ? (y >= 0) : (z < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && i == ITER_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (cmd.start) begin
      x   <= x_in;
      y   <= y_in;
      z   <= z_in;
      vec <= cmd.vec;
      i   <= '0;
    end else if (busy) begin
      i <= i + 1'b1;
      if (up) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end
    end
  end

  assign y_out = y;
  assign z_out = z;

endmodule
`default_nettype wire

[src/psfr_sqrt.sv]
`default_nettype none
module psfr_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [60:0] n_in,
  output logic             done,
  output logic [30:0]      root
);
  logic [60:0] n, r, bb, rb;
  logic [4:0]  k;
  logic        busy;

  assign bb   = 61'(1) << {k, 1'b0};
  assign rb   = r + bb;
  assign root = r[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && k == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      n <= n_in;
      r <= '0;
      k <= 5'd30;
    end else if (busy) begin
      k <= k - 1'b1;
      if (n >= rb) begin
        n <= n - rb;
        r <= (r >> 1) + bb;
      end else begin
        r <= r >> 1;
      end
    end
  end

endmodule
`default_nettype wire

[src/psfr_div.sv]
`default_nettype none
module psfr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [61:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quo
);
  logic [31:0] rem;
  logic [30:0] low;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] t;
  logic        ge;
  logic [32:0] t_sub;

  assign t     = {rem, low[30]};
  assign ge    = t >= {1'b0, den};
  assign t_sub = t - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // quotient of 2^31 or more clamps at once
        if ({1'b0, num[61:31]} >= den) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= {1'b0, num[61:31]};
      low <= num[30:0];
      cnt <= 5'd31;
      quo <= ({1'b0, num[61:31]} >= den) ? 32'h8000_0000 : 32'd0;
    end else if (busy) begin
      rem <= ge ? t_sub[31:0] : t[31:0];
      quo <= {quo[30:0], ge};
      low <= {low[29:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/pose_smoother_flip_reject.sv]
`default_nettype none
// per-marker pose smoother with flip rejection
//
// s_* carries one raw pose item; m_* returns exactly one filtered pose per
// item; cfg_* writes one of five registers (index 0..4) and is always ready,
// it is meant to be written only while no item is in flight.
// each item reads the marker table, then one of three outcomes:
//   snapped (first sighting or long gap): straight from the check to the write
//   held (rotation jump rejected): after the quaternion dot product
//   blended: paced by the iterative cordic (atan2 and one sine, plus two
//   more sines unless the angle is tiny), the bit-serial square root and,
//   unless the angle is tiny, two bit-serial divisions, with one shared
//   multiply-accumulate unit doing every product in sequence
// one item is in work at a time; s_tready is high only when idle.
// the result sits in an output register, so the next item may be accepted
// while m_tvalid waits for m_tready; a stalled receiver only delays the
// final table write of the following item.
// after reset the liveness table is cleared one slot a cycle, all
// MARKER_SLOTS slots, while s_tready stays low.
module pose_smoother_flip_reject #(
  parameter int MARKER_SLOTS = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // marker_id, now_us, raw_tx, raw_ty, raw_tz, raw_qx, raw_qy, raw_qz, raw_qw, pad
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [215:0] s_tdata,
  // out_id, out_tx, out_ty, out_tz, out_qx, out_qy, out_qz, out_qw, pad
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,
  // pose_status
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  import psfr_pkg::*;

  localparam int SLOT_W = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;

  // config registers
  logic [5:0]  small_id;
  logic [16:0] alpha_small;
  logic [16:0] alpha_default;
  logic [23:0] timeout_us;
  logic [14:0] flip_cos;

  // control
  state_t            state, state_next;
  group_t            group;
  logic              kick;
  logic [1:0]        cnt;
  logic              wcnt;
  logic [1:0]        last_cnt;
  logic [SLOT_W-1:0] clr_addr;
  logic [1:0]        ax, qc;

  // item data
  logic [5:0]         id_q;
  logic [47:0]        now_q;
  logic [SLOT_W-1:0]  slot_q;
  logic signed [31:0] rt [3];
  logic signed [31:0] kt [3];
  logic signed [31:0] ot [3];
  logic signed [15:0] rq [4];
  logic signed [15:0] kq [4];
  logic signed [15:0] oq [4];
  logic [1:0]         status_q;
  logic [16:0]        a_q;
  logic [16:0]        oma;
  logic [16:0]        a_sel;
  logic               dot_neg;
  logic [32:0]        dot_mag;
  logic [30:0]        p_q;
  logic [60:0]        nsq;
  logic [30:0]        s_q;
  logic [32:0]        theta;
  logic signed [CW-1:0] d_q;
  logic [32:0]        t0_q, t1_q;
  logic signed [CW-1:0] sn_q;
  logic signed [CW-1:0] sn_abs;
  logic signed [32:0] w0, w1;

  // table
  logic              live_mem [MARKER_SLOTS];
  pose_rec_t         pose_mem [MARKER_SLOTS];
  logic              live_rd;
  pose_rec_t         pose_rd;
  logic [SLOT_W-1:0] slot_lut [64];
  logic [SLOT_W-1:0] slot_in;
  logic              live_we, live_wd, pose_we;
  logic [SLOT_W-1:0] live_addr;
  pose_rec_t         pose_wd;

  // shared units
  logic                    mac_issue, mac_fresh;
  logic signed [MAC_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd_t, rnd_q, q_sh;
  logic signed [15:0]      q_sat;
  logic                    sqrt_start, sqrt_done;
  logic [30:0]             root;
  cordic_cmd_t             ccmd;
  logic signed [CW-1:0]    cx, cy, cz, c_y, c_z;
  logic                    c_done;
  logic                    div_start, div_done;
  logic [31:0]             quo;

  // decisions
  logic [47:0] gap;
  logic        snap_c, held_c, linear_c, out_free, out_load;

  // id to slot, modulo the table size
  for (genvar g = 0; g < 64; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % MARKER_SLOTS);
  end
  assign slot_in = slot_lut[s_tdata[5:0]];

  assign cfg_ready = 1'b1;
  assign oma       = 17'd65536 - a_q;
  assign a_sel     = (id_q == small_id) ? alpha_small : alpha_default;
  assign gap       = now_q - pose_rd.seen;
  assign snap_c    = !live_rd || (gap > {24'd0, timeout_us});
  assign held_c    = dot_mag < {3'd0, flip_cos, 15'd0};
  assign linear_c  = d_q < CW'(65536);
  assign out_free  = !m_tvalid || m_tready;
  assign sn_abs    = sn_q[CW-1] ? -sn_q : sn_q;

  // rounding of accumulated sums
  assign rnd_t = acc + ACC_W'(32768);
  assign rnd_q = acc + ACC_W'(536870912);
  assign q_sh  = rnd_q >>> 30;
  always_comb begin
    if (q_sh > ACC_W'(32767)) begin
      q_sat = 16'sh7fff;
    end else if (q_sh < -ACC_W'(32768)) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q_sh[15:0];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      small_id      <= 6'd3;
      alpha_small   <= 17'd6554;
      alpha_default <= 17'd19661;
      timeout_us    <= 24'd500000;
      flip_cos      <= 15'd23170;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SMALL_ID:      small_id      <= cfg_data[5:0];
        CFG_ALPHA_SMALL:   alpha_small   <= cfg_data[16:0];
        CFG_ALPHA_DEFAULT: alpha_default <= cfg_data[16:0];
        CFG_TIMEOUT:       timeout_us    <= cfg_data;
        CFG_FLIP_COS:      flip_cos      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // group decode
  always_comb begin
    ax       = 2'd0;
    qc       = 2'd0;
    last_cnt = 2'd1;
    case (group)
      G_DOT: begin
        qc       = cnt;
        last_cnt = 2'd3;
      end
      G_TY: ax = 2'd1;
      G_TZ: ax = 2'd2;
      G_PSQ, G_T0, G_T1: last_cnt = 2'd0;
      G_QY: qc = 2'd1;
      G_QZ: qc = 2'd2;
      G_QW: qc = 2'd3;
      default: ;
    endcase
  end

  // multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (group) inside
      G_DOT: begin
        op_a = MAC_W'(kq[qc]);
        op_b = MAC_W'(rq[qc]);
      end
      G_TX, G_TY, G_TZ: begin
        if (!cnt[0]) begin
          op_a = {16'd0, a_q};
          op_b = MAC_W'(rt[ax]);
        end else begin
          op_a = {16'd0, oma};
          op_b = MAC_W'(kt[ax]);
        end
      end
      G_PSQ: begin
        op_a = {2'd0, p_q};
        op_b = {2'd0, p_q};
      end
      G_T0: begin
        op_a = {16'd0, oma};
        op_b = theta;
      end
      G_T1: begin
        op_a = {16'd0, a_q};
        op_b = theta;
      end
      G_QX, G_QY, G_QZ, G_QW: begin
        if (!cnt[0]) begin
          op_a = MAC_W'(kq[qc]);
          op_b = w0;
        end else begin
          op_a = MAC_W'(rq[qc]);
          op_b = w1;
        end
      end
      default: ;
    endcase
  end

  // unit operands
  always_comb begin
    cx = CW'(36'sd1073741824);
    cy = '0;
    cz = '0;
    unique case (state)
      ST_ATAN: begin
        cx = CW'({5'd0, p_q});
        cy = CW'({5'd0, s_q});
      end
      ST_SIN_TH: cz = CW'({3'd0, theta});
      ST_SIN0:   cz = CW'({3'd0, t0_q});
      ST_SIN1:   cz = CW'({3'd0, t1_q});
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == SLOT_W'(MARKER_SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK:  state_next = snap_c ? ST_WRITE : ST_MAC;
      ST_MAC:    if (cnt == last_cnt) state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (wcnt) begin
          case (group)
            G_DOT:   state_next = ST_FLIP;
            G_PSQ:   state_next = ST_SQRT;
            G_T1:    state_next = ST_SIN0;
            G_QW:    state_next = ST_WRITE;
            default: state_next = ST_MAC;
          endcase
        end
      end
      ST_FLIP:   state_next = held_c ? ST_WRITE : ST_MAC;
      ST_SQRT:   if (sqrt_done) state_next = ST_ATAN;
      ST_ATAN:   if (c_done) state_next = ST_SIN_TH;
      ST_SIN_TH: if (c_done) state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_MAC;
      ST_SIN0:   if (c_done) state_next = ST_DIV0;
      ST_DIV0:   if (div_done) state_next = ST_SIN1;
      ST_SIN1:   if (c_done) state_next = ST_DIV1;
      ST_DIV1:   if (div_done) state_next = ST_MAC;
      ST_WRITE:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    mac_issue  = 1'b0;
    mac_fresh  = 1'b0;
    sqrt_start = 1'b0;
    ccmd       = '0;
    div_start  = 1'b0;
    live_we    = 1'b0;
    live_wd    = 1'b0;
    live_addr  = slot_q;
    pose_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        live_we   = 1'b1;
        live_addr = clr_addr;
      end
      ST_IDLE: s_tready = 1'b1;
      ST_MAC: begin
        mac_issue = 1'b1;
        mac_fresh = (cnt == 2'd0);
      end
      ST_SQRT: sqrt_start = kick;
      ST_ATAN: begin
        ccmd.start = kick;
        ccmd.vec   = 1'b1;
      end
      ST_SIN_TH, ST_SIN0, ST_SIN1: ccmd.start = kick;
      ST_DIV0, ST_DIV1: div_start = kick;
      ST_WRITE: begin
        live_we  = out_free;
        live_wd  = 1'b1;
        pose_we  = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      kick     <= 1'b0;
      clr_addr <= '0;
      cnt      <= '0;
      wcnt     <= 1'b0;
    end else begin
      state    <= state_next;
      kick     <= (state_next != state);
      clr_addr <= (state == ST_CLEAR) ? clr_addr + 1'b1 : clr_addr;
      cnt      <= (state == ST_MAC && state_next == ST_MAC) ? cnt + 1'b1 : 2'd0;
      wcnt     <= (state == ST_MWAIT) ? !wcnt : 1'b0;
    end
  end

  // table
  assign pose_wd.seen = now_q;
  assign pose_wd.tx   = ot[0];
  assign pose_wd.ty   = ot[1];
  assign pose_wd.tz   = ot[2];
  assign pose_wd.quat = {oq[3], oq[2], oq[1], oq[0]};

  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_addr] <= live_wd;
    if (pose_we) pose_mem[slot_q] <= pose_wd;
    live_rd <= live_mem[slot_in];
    pose_rd <= pose_mem[slot_in];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        id_q   <= s_tdata[5:0];
        now_q  <= s_tdata[53:6];
        slot_q <= slot_in;
        rt[0]  <= s_tdata[85:54];
        rt[1]  <= s_tdata[117:86];
        rt[2]  <= s_tdata[149:118];
        rq[0]  <= s_tdata[165:150];
        rq[1]  <= s_tdata[181:166];
        rq[2]  <= s_tdata[197:182];
        rq[3]  <= s_tdata[213:198];
      end
      ST_CHECK: begin
        a_q   <= (a_sel > 17'd65536) ? 17'd65536 : a_sel;
        kt[0] <= pose_rd.tx;
        kt[1] <= pose_rd.ty;
        kt[2] <= pose_rd.tz;
        for (int c = 0; c < 4; c++) kq[c] <= pose_rd.quat[c];
        group <= G_DOT;
        if (snap_c) begin
          status_q <= POSE_SNAPPED;
          for (int c = 0; c < 3; c++) ot[c] <= rt[c];
          for (int c = 0; c < 4; c++) oq[c] <= rq[c];
        end
      end
      ST_MWAIT: begin
        if (wcnt) begin
          if (group != G_QW) group <= group_t'(group + 4'd1);
          case (group) inside
            G_DOT: begin
              dot_neg <= acc[ACC_W-1];
              dot_mag <= acc[ACC_W-1] ? 33'(-acc) : acc[32:0];
            end
            G_TX, G_TY, G_TZ: ot[ax] <= rnd_t[47:16];
            G_PSQ: nsq <= {1'b1, 60'd0} - acc[60:0];
            G_T0: t0_q <= acc[48:16];
            G_T1: t1_q <= acc[48:16];
            G_QX, G_QY, G_QZ, G_QW: oq[qc] <= q_sat;
            default: ;
          endcase
        end
      end
      ST_FLIP: begin
        group <= G_TX;
        p_q   <= (dot_mag > 33'h0_4000_0000) ? 31'h4000_0000 : dot_mag[30:0];
        if (held_c) begin
          status_q <= POSE_HELD;
          for (int c = 0; c < 3; c++) ot[c] <= kt[c];
          for (int c = 0; c < 4; c++) oq[c] <= kq[c];
        end else begin
          status_q <= POSE_BLENDED;
        end
      end
      ST_SQRT:   if (sqrt_done) s_q <= root;
      ST_ATAN:   if (c_done) theta <= c_z[CW-1] ? 33'd0 : c_z[32:0];
      ST_SIN_TH: if (c_done) d_q <= c_y;
      ST_WEIGHT: begin
        // tiny angle: plain linear weights
        if (linear_c) begin
          group <= G_QX;
          w0    <= {2'd0, oma, 14'd0};
          w1    <= dot_neg ? -{2'd0, a_q, 14'd0} : {2'd0, a_q, 14'd0};
        end else begin
          group <= G_T0;
        end
      end
      ST_SIN0, ST_SIN1: if (c_done) sn_q <= c_y;
      ST_DIV0: if (div_done) w0 <= sn_q[CW-1] ? -{1'b0, quo} : {1'b0, quo};
      ST_DIV1: begin
        group <= G_QX;
        if (div_done) begin
          w1 <= (sn_q[CW-1] ^ dot_neg) ? -{1'b0, quo} : {1'b0, quo};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {2'd0, oq[3], oq[2], oq[1], oq[0], ot[2], ot[1], ot[0], id_q};
      m_tuser <= status_q;
    end
  end

  psfr_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (mac_issue),
    .fresh (mac_fresh),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  psfr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n_in  (nsq),
    .done  (sqrt_done),
    .root  (root)
  );

  psfr_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ccmd),
    .x_in  (cx),
    .y_in  (cy),
    .z_in  (cz),
    .done  (c_done),
    .y_out (c_y),
    .z_out (c_z)
  );

  psfr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({sn_abs[31:0], 30'd0}),
    .den   (d_q[31:0]),
    .done  (div_done),
    .quo   (quo)
  );

endmodule
`default_nettype wire

[src/psfr_checker.sv]
`default_nettype none
module psfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [1:0] m_tuser
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // status is never the unused code
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == 2'd0 || m_tuser == 2'd1 || m_tuser == 2'd2))
    else $error("bad pose status");

  // table clearing keeps the input closed right after reset
  a_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open during table clear");

  // an accepted item keeps the input closed in the cycle after the accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after accept");

  // a new result only comes out of a busy cycle
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without work");

endmodule

bind pose_smoother_flip_reject psfr_checker u_chk (.*);
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import psfr_pkg::*;

  localparam logic [2:0] CFG_SPARE = 3'd7;   // index past the register list
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam int CYCLE_LIMIT = 2000000;
  localparam longint ARC_TAB [16] = '{
    843314857, 497837830, 263043837, 133525159, 67021688, 33543515,
    16775851, 8388438, 4194283, 2097150, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  typedef struct {
    logic [5:0]  id;
    logic [47:0] now;
    int          t [3];
    shortint     q [4];   // x, y, z, w
  } raw_pose_t;

  typedef struct {
    logic [5:0] id;
    int         t [3];
    shortint    q [4];
    logic [1:0] status;
  } smooth_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [215:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  pose_smoother_flip_reject dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the register file
  logic [5:0]  small_id = 6'd3;
  logic [16:0] alpha_sm = 17'd6554;
  logic [16:0] alpha_df = 17'd19661;
  logic [23:0] timeout_us = 24'd500000;
  logic [14:0] flip_cos = 15'd23170;

  // shadow of the marker table
  bit          live [64];
  logic [47:0] seen [64];
  int          keep_t [64][3];
  shortint     keep_q [64][4];

  raw_pose_t    pending_poses [$];
  smooth_pose_t expected_poses [$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;       // no idling in the last part

  // unscaled cordic sine, q30 radians in, gain*sin in q30 out
  function automatic longint rot_sine(longint phi);
    longint x = ONE_Q30, y = 0, z = phi, dx, dy;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end else begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end
    end
    return y;
  endfunction

  // cordic vectoring atan2(y, x) in q30
  function automatic longint vec_angle(longint x0, longint y0);
    longint x = x0, y = y0, z = 0, dx, dy;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARC_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ARC_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n0);
    longint unsigned n = n0, r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip_weight(longint w);
    if (w > (64'sd1 << 31)) return 64'sd1 << 31;
    if (w < -(64'sd1 << 31)) return -(64'sd1 << 31);
    return w;
  endfunction

  // predict one filtered pose and advance the shadow table
  function automatic smooth_pose_t smooth_pose(raw_pose_t r);
    smooth_pose_t o;
    int s = r.id;
    longint a, dot, p, theta, d, w0, w1, v, t0, t1;
    logic [47:0] gap;
    a = (r.id == small_id) ? alpha_sm : alpha_df;
    if (a > 65536) a = 65536;
    o.id = r.id;
    gap = r.now - seen[s];
    if (!live[s] || gap > timeout_us) begin
      o.status = POSE_SNAPPED;
      o.t = r.t;
      o.q = r.q;
    end else begin
      dot = 0;
      for (int c = 0; c < 4; c++) dot += longint'(keep_q[s][c]) * longint'(r.q[c]);
      p = dot < 0 ? -dot : dot;
      if (p < (longint'(flip_cos) <<< 15)) begin
        o.status = POSE_HELD;
        o.t = keep_t[s];
        o.q = keep_q[s];
      end else begin
        o.status = POSE_BLENDED;
        for (int c = 0; c < 3; c++)
          o.t[c] = int'((a * r.t[c] + (65536 - a) * keep_t[s][c] + 32768) >>> 16);
        if (p > ONE_Q30) p = ONE_Q30;
        theta = vec_angle(p, longint'(int_root((64'd1 << 60) - longint'(p * p))));
        if (theta < 0) theta = 0;
        d = rot_sine(theta);
        if (d < (64'sd1 << 16)) begin
          // tiny angle: linear weights
          w0 = (65536 - a) <<< 14;
          w1 = a <<< 14;
        end else begin
          t0 = ((65536 - a) * theta) >>> 16;
          t1 = (a * theta) >>> 16;
          w0 = clip_weight(rot_sine(t0) * ONE_Q30 / d);
          w1 = clip_weight(rot_sine(t1) * ONE_Q30 / d);
        end
        if (dot < 0) w1 = -w1;   // shortest path
        for (int c = 0; c < 4; c++) begin
          v = (longint'(keep_q[s][c]) * w0 + longint'(r.q[c]) * w1 + (64'sd1 << 29)) >>> 30;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          o.q[c] = shortint'(v);
        end
      end
    end
    live[s] = 1'b1;
    seen[s] = r.now;
    if (o.status != POSE_HELD) begin
      keep_t[s] = o.t;
      keep_q[s] = o.q;
    end
    return o;
  endfunction

  // driver: sender side with random gaps
  raw_pose_t cur_pose;
  int send_gap = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_poses.push_back(smooth_pose(cur_pose));
        void'(pending_poses.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_poses.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 14);
          end else begin
            nv = 1'b1;
            cur_pose = pending_poses[0];
            s_tdata <= {2'b00, cur_pose.q[3], cur_pose.q[2], cur_pose.q[1], cur_pose.q[0],
                        cur_pose.t[2], cur_pose.t[1], cur_pose.t[0], cur_pose.now, cur_pose.id};
          end
        end
      end
      s_tvalid <= nv;
    end
  end

  // monitor: receiver side with random stalls
  int stall_left = 0;
  always @(posedge clk) begin
    smooth_pose_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_poses.size() == 0) begin
          $error("unexpected item out_id=%0d", m_tdata[5:0]);
          errors++;
        end else begin
          e = expected_poses.pop_front();
          if (m_tdata[5:0] !== e.id) begin
            $error("out_id expected %0d actual %0d", e.id, m_tdata[5:0]); errors++;
          end
          for (int c = 0; c < 3; c++)
            if ($signed(m_tdata[6+32*c +: 32]) !== e.t[c]) begin
              $error("out_t%0d expected %0d actual %0d", c, e.t[c],
                     $signed(m_tdata[6+32*c +: 32]));
              errors++;
            end
          for (int c = 0; c < 4; c++)
            if ($signed(m_tdata[102+16*c +: 16]) !== e.q[c]) begin
              $error("out_q%0d expected %0d actual %0d", c, e.q[c],
                     $signed(m_tdata[102+16*c +: 16]));
              errors++;
            end
          if (m_tuser !== e.status) begin
            $error("pose_status expected %0d actual %0d", e.status, m_tuser); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus-side memory of what each marker was last sent
  logic [47:0] last_now [64];
  int          last_t [64][3];
  shortint     last_q [64][4];

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SMALL_ID:      small_id = val[5:0];
      CFG_ALPHA_SMALL:   alpha_sm = val[16:0];
      CFG_ALPHA_DEFAULT: alpha_df = val[16:0];
      CFG_TIMEOUT:       timeout_us = val;
      CFG_FLIP_COS:      flip_cos = val[14:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_poses.size() != 0 || expected_poses.size() != 0 || s_tvalid);
  endtask

  // queue a pose and remember it as the marker's latest
  task automatic send(input logic [5:0] id, input logic [47:0] now, input int tx,
                      input int ty, input int tz, input shortint qx, input shortint qy,
                      input shortint qz, input shortint qw);
    raw_pose_t r;
    r.id = id; r.now = now;
    r.t[0] = tx; r.t[1] = ty; r.t[2] = tz;
    r.q[0] = qx; r.q[1] = qy; r.q[2] = qz; r.q[3] = qw;
    last_now[id] = now; last_t[id] = r.t; last_q[id] = r.q;
    pending_poses.push_back(r);
  endtask

  // near-unit w for given x, y, z, sign chosen by caller
  function automatic shortint unit_w(int x, int y, int z);
    real m;
    m = 32767.0 * 32767.0 - real'(x) * x - real'(y) * y - real'(z) * z;
    if (m < 0.0) m = 0.0;
    return shortint'($rtoi($sqrt(m)));
  endfunction

  function automatic int nudge(int v, int span, int lim);
    int n;
    n = v + $urandom_range(0, 2 * span) - span;
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
    return n;
  endfunction

  task automatic random_poses(input int n);
    int kind, x, y, z;
    logic [5:0] id;
    logic [47:0] now;
    shortint w;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: id = small_id;
        1: id = $urandom_range(0, 63);
        default: id = $urandom_range(0, 7);
      endcase
      if (kind < 65) begin
        // well-formed follow-up close in time and rotation
        now = last_now[id] + $urandom_range(0, timeout_us);
        x = nudge(last_q[id][0], 1500, 18000);
        y = nudge(last_q[id][1], 1500, 18000);
        z = nudge(last_q[id][2], 1500, 18000);
        w = unit_w(x, y, z);
        if (last_q[id][3] < 0) w = -w;
        if ($urandom_range(0, 4) == 0) begin
          x = -x; y = -y; z = -z; w = -w;
        end
        if ($urandom_range(0, 5) == 0)
          send(id, now, $urandom, $urandom, $urandom, x, y, z, w);
        else
          send(id, now, nudge(last_t[id][0], 200000, 2000000000),
               nudge(last_t[id][1], 200000, 2000000000),
               nudge(last_t[id][2], 200000, 2000000000), x, y, z, w);
      end else if (kind < 75) begin
        // half-turn relative rotation: dot is zero
        now = last_now[id] + $urandom_range(0, timeout_us);
        send(id, now, $urandom, $urandom, $urandom, last_q[id][3], -last_q[id][2],
             last_q[id][1], -last_q[id][0]);
      end else if (kind < 85) begin
        // gap beyond the timeout, sometimes any 48-bit step
        if ($urandom_range(0, 1) == 0)
          now = last_now[id] + timeout_us + $urandom_range(1, 5000);
        else
          now = {$urandom, $urandom};
        x = $urandom_range(0, 36000) - 18000;
        y = $urandom_range(0, 36000) - 18000;
        z = $urandom_range(0, 36000) - 18000;
        send(id, now, $urandom, $urandom, $urandom, x, y, z, unit_w(x, y, z));
      end else begin
        // noise: every field random
        send(id, {$urandom, $urandom}, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      last_now[i] = '0;
      last_t[i] = '{0, 0, 0};
      last_q[i] = '{0, 0, 0, 32767};
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    send(3, 48'd1000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 32767);   // first sighting
    send(3, 48'd2000, 65536, -65536, 100, 1000, 0, 0, 32751);           // small-id blend
    send(3, 48'd3000, 0, 0, 0, -1000, 0, 0, -32751);                    // negated, short path
    send(3, 48'd4000, 5, 5, 5, 32767, 0, 0, 0);                         // flip, held
    send(3, 48'd5000, 5, 5, 5, 0, 0, 0, 32767);                         // held pose refreshed time
    send(3, 48'd600000, 1, 2, 3, 0, 23170, 0, 23170);                   // long gap, snap
    send(3, 48'd600001, 1, 2, 3, 0, 23170, 0, 23170);                   // identical, tiny angle
    send(5, 48'hffff_ffff_fff0, 32'sh80000000, 32'sh7fffffff, -1,
         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);                   // extremes
    send(5, 48'd5, 32'sh7fffffff, 32'sh80000000, 0,
         16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);                   // time wrap blend
    send(63, 48'hffff_ffff_ffff, -7, 7, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
         16'sh7fff);
    send(63, 48'd3, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send(0, 48'd0, 0, 0, 0, 0, 0, 0, 32767);
    send(0, 48'd500000, 1000, 1000, 1000, 0, 2000, 0, 32706);           // gap exactly timeout
    send(0, 48'd1000001, 0, 0, 0, 0, 0, 0, 32767);                      // one past timeout
    send(0, 48'd1000002, 0, 0, 0, 16384, 0, 0, 28377);                  // 60 degree turn
    random_poses(110);
    wait_idle();

    // minimum alphas, marker id zero small, tight timeout
    write_reg(CFG_SMALL_ID, 24'd0);
    write_reg(CFG_ALPHA_SMALL, 24'd0);
    write_reg(CFG_ALPHA_DEFAULT, 24'd1);
    write_reg(CFG_TIMEOUT, 24'd0);
    write_reg(CFG_FLIP_COS, 24'd0);
    write_reg(CFG_SPARE, 24'hffffff);                                   // ignored index
    random_poses(120);
    wait_idle();

    // small alpha above one, default alpha at one, widest timeout, strictest flip test
    write_reg(CFG_SMALL_ID, 24'd63);
    write_reg(CFG_ALPHA_SMALL, 24'd131071);
    write_reg(CFG_ALPHA_DEFAULT, 24'd65536);
    write_reg(CFG_TIMEOUT, 24'hffffff);
    write_reg(CFG_FLIP_COS, 24'd32767);
    random_poses(120);
    wait_idle();

    // mid settings, moderate flip threshold
    write_reg(CFG_SMALL_ID, 24'd5);
    write_reg(CFG_ALPHA_SMALL, 24'd32768);
    write_reg(CFG_ALPHA_DEFAULT, 24'd65535);
    write_reg(CFG_TIMEOUT, 24'd20000);
    write_reg(CFG_FLIP_COS, 24'd16000);
    random_poses(150);
    // hold off until every result is back, then carry on in the same setting
    wait_idle();
    random_poses(100);
    wait_idle();

    for (int k = 0; k < 2; k++) begin
      write_reg(CFG_SMALL_ID, $urandom_range(0, 7));
      write_reg(CFG_ALPHA_SMALL, $urandom_range(0, 70000));
      write_reg(CFG_ALPHA_DEFAULT, $urandom_range(0, 70000));
      write_reg(CFG_TIMEOUT, $urandom_range(1000, 2000000));
      write_reg(CFG_FLIP_COS, $urandom_range(0, 32767));
      random_poses(110);
      wait_idle();
    end

    // back to reset values, no idling to the end
    write_reg(CFG_SMALL_ID, 24'd3);
    write_reg(CFG_ALPHA_SMALL, 24'd6554);
    write_reg(CFG_ALPHA_DEFAULT, 24'd19661);
    write_reg(CFG_TIMEOUT, 24'd500000);
    write_reg(CFG_FLIP_COS, 24'd23170);
    calm = 1'b1;
    random_poses(110);
    wait_idle();
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
src/psfr_pkg.sv
src/psfr_mac.sv
src/psfr_cordic.sv
src/psfr_sqrt.sv
src/psfr_div.sv
src/pose_smoother_flip_reject.sv
src/psfr_checker.sv
bench/testbench.sv
